// ===== rtl/cda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Transaction types, request codes and Gregorian calendar helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int YEAR_BITS_DEF  = 16;

	localparam logic [3:0] MON_JAN  = 4'd1;
	localparam logic [3:0] MON_FEB  = 4'd2;
	localparam logic [3:0] MON_DEC  = 4'd12;
	localparam logic [4:0] DAY_LEAP = 5'd29;

	localparam logic [8:0] DAYS_COMMON = 9'd365;
	localparam logic [8:0] DAYS_LEAP   = 9'd366;
	localparam logic [8:0] CYCLE_LAST  = 9'd399;
	localparam logic [15:0] CYCLE_LEN  = 16'd400;

	typedef enum logic [2:0] {
		REQ_LOAD = 3'd0,
		REQ_NEXT = 3'd1,
		REQ_PREV = 3'd2,
		REQ_ADD  = 3'd3,
		REQ_SUB  = 3'd4
	} req_code_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [4:0]  day_in;
		logic [3:0]  month_in;
		logic [15:0] year_in;
		logic [15:0] day_count;
	} req_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [15:0] year_out;
	} rsp_t;

	typedef struct packed {
		logic done;
		rsp_t date;
	} seq_stat_t;

	// leap test on the year taken modulo 400
	function automatic logic leap_f(input logic [8:0] r);
		logic res;
		res = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
		return res;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m) inside
			MON_FEB:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/cda_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one date request per transaction.
// ----------------------------------------------------------------------------
interface cda_req_if import cda_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/cda_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the current date per transaction.
// ----------------------------------------------------------------------------
interface cda_rsp_if import cda_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/cda_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared subtract/compare unit
// Computes a - b and flags a >= b; reused by the year-reduction and add/subtract phases.
// ----------------------------------------------------------------------------
module cda_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

// ===== rtl/cda_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date sequencer
// Holds the date and steps it by years, months and days through the ALU.
// ----------------------------------------------------------------------------
module cda_seq import cda_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int YEAR_BITS  = YEAR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  req_t      in_item,
	input  logic      out_free,
	output seq_stat_t stat
);

	localparam int W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int LW = (YEAR_BITS < 16) ? YEAR_BITS : 16;
	localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
	localparam logic [YEAR_BITS-1:0] YMAX = {YEAR_BITS{1'b1}};
	localparam logic [8:0] YMAX_MOD = 9'((((64'd1) << YEAR_BITS) - 64'd1) % 64'd400);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MODR  = 8'b0000_0010,
		ST_CLAMP = 8'b0000_0100,
		ST_YADD  = 8'b0000_1000,
		ST_MADD  = 8'b0001_0000,
		ST_YSUB  = 8'b0010_0000,
		ST_MSUB  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [4:0]           day_q;
	logic [3:0]           mon_q;
	logic [YEAR_BITS-1:0] year_q;
	logic [8:0]           m400_q;
	logic [W-1:0]         wrk_q;
	logic [2:0]           k_q;

	logic [W-1:0]         alu_b;
	logic [W-1:0]         alu_diff;
	logic                 alu_ge;
	logic [W-1:0]         red;

	logic [YEAR_BITS-1:0] yinc_year, ydec_year;
	logic [8:0]           yinc_m, ydec_m;
	logic                 leap_cur, leap_nxt, leap_prv;
	logic [4:0]           len_cur;
	logic                 feb29;
	logic [3:0]           mon_adv, pd_mon;
	logic [4:0]           nd_day, pd_day;
	logic [3:0]           nd_mon;
	logic                 nd_wrap, pd_wrap;
	logic [5:0]           rest;
	logic [8:0]           span_add, span_sub;
	logic [3:0]           ld_mon;
	logic [4:0]           ld_day;
	logic [YEAR_BITS-1:0] ld_year;

	cda_alu #(.W(W)) u_alu (
		.a    (wrk_q),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	always_comb begin
		yinc_year = (year_q == YMAX) ? '0 : year_q + 1'b1;
		yinc_m    = (year_q == YMAX) ? 9'd0 :
		            ((m400_q == CYCLE_LAST) ? 9'd0 : m400_q + 9'd1);
		ydec_year = (year_q == '0) ? YMAX : year_q - 1'b1;
		ydec_m    = (year_q == '0) ? YMAX_MOD :
		            ((m400_q == 9'd0) ? CYCLE_LAST : m400_q - 9'd1);
		leap_cur  = leap_f(m400_q);
		leap_nxt  = leap_f(yinc_m);
		leap_prv  = leap_f(ydec_m);
		len_cur   = month_len(mon_q, leap_cur);
		feb29     = (day_q == DAY_LEAP) && (mon_q == MON_FEB);

		mon_adv = (mon_q == MON_DEC) ? MON_JAN : mon_q + 4'd1;
		pd_mon  = (mon_q == MON_JAN) ? MON_DEC : mon_q - 4'd1;

		if (day_q < len_cur) begin
			nd_day  = day_q + 5'd1;
			nd_mon  = mon_q;
			nd_wrap = 1'b0;
		end else begin
			nd_day  = 5'd1;
			nd_mon  = mon_adv;
			nd_wrap = (mon_q == MON_DEC);
		end

		if (day_q > 5'd1) begin
			pd_day  = day_q - 5'd1;
			pd_wrap = 1'b0;
		end else begin
			pd_day  = month_len(pd_mon, leap_cur);
			pd_wrap = (mon_q == MON_JAN);
		end

		rest     = 6'(len_cur) - 6'(day_q) + 6'd1;
		span_add = (mon_q <= MON_FEB) ? (leap_cur ? DAYS_LEAP : DAYS_COMMON)
		                              : (leap_nxt ? DAYS_LEAP : DAYS_COMMON);
		span_sub = (mon_q > MON_FEB)  ? (leap_cur ? DAYS_LEAP : DAYS_COMMON)
		                              : (leap_prv ? DAYS_LEAP : DAYS_COMMON);

		ld_mon  = (in_item.month_in == 4'd0) ? MON_JAN :
		          ((in_item.month_in > MON_DEC) ? MON_DEC : in_item.month_in);
		ld_day  = (in_item.day_in == 5'd0) ? 5'd1 : in_item.day_in;
		ld_year = YEAR_BITS'(in_item.year_in[LW-1:0]);
	end

	always_comb begin
		unique case (state_q)
			ST_MODR:          alu_b = W'(CYCLE_LEN << k_q);
			ST_YADD:          alu_b = feb29 ? W'(1) : W'(span_add);
			ST_YSUB:          alu_b = feb29 ? W'(1) : W'(span_sub);
			ST_MADD:          alu_b = W'(rest);
			ST_MSUB:          alu_b = W'(day_q);
			default:          alu_b = '0;
		endcase
		red = alu_ge ? alu_diff : wrk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			day_q   <= 5'd1;
			mon_q   <= MON_JAN;
			year_q  <= YEAR_BITS'(1);
			m400_q  <= 9'd1;
			wrk_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (in_item.req_type)
							REQ_LOAD: begin
								mon_q   <= ld_mon;
								day_q   <= ld_day;
								year_q  <= ld_year;
								wrk_q   <= W'(in_item.year_in[LW-1:0]);
								k_q     <= 3'd7;
								state_q <= ST_MODR;
							end
							REQ_NEXT: begin
								day_q <= nd_day;
								mon_q <= nd_mon;
								if (nd_wrap) begin
									year_q <= yinc_year;
									m400_q <= yinc_m;
								end
								state_q <= ST_DONE;
							end
							REQ_PREV: begin
								day_q <= pd_day;
								if (day_q == 5'd1) begin
									mon_q <= pd_mon;
								end
								if (pd_wrap) begin
									year_q <= ydec_year;
									m400_q <= ydec_m;
								end
								state_q <= ST_DONE;
							end
							REQ_ADD: begin
								wrk_q   <= W'(in_item.day_count[CW-1:0]);
								state_q <= ST_YADD;
							end
							REQ_SUB: begin
								wrk_q   <= W'(in_item.day_count[CW-1:0]);
								state_q <= ST_YSUB;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_MODR: begin
					wrk_q <= red;
					if (k_q == 3'd0) begin
						m400_q  <= red[8:0];
						state_q <= ST_CLAMP;
					end else begin
						k_q <= k_q - 3'd1;
					end
				end
				ST_CLAMP: begin
					if (day_q > len_cur) begin
						day_q <= len_cur;
					end
					state_q <= ST_DONE;
				end
				ST_YADD: begin
					if (wrk_q == '0) begin
						state_q <= ST_DONE;
					end else if (feb29) begin
						day_q <= nd_day;
						mon_q <= nd_mon;
						wrk_q <= alu_diff;
					end else if (alu_ge) begin
						wrk_q  <= alu_diff;
						year_q <= yinc_year;
						m400_q <= yinc_m;
					end else begin
						state_q <= ST_MADD;
					end
				end
				ST_MADD: begin
					if (alu_ge) begin
						wrk_q <= alu_diff;
						day_q <= 5'd1;
						mon_q <= mon_adv;
						if (mon_q == MON_DEC) begin
							year_q <= yinc_year;
							m400_q <= yinc_m;
						end
					end else begin
						day_q   <= day_q + wrk_q[4:0];
						state_q <= ST_DONE;
					end
				end
				ST_YSUB: begin
					if (wrk_q == '0) begin
						state_q <= ST_DONE;
					end else if (feb29) begin
						day_q <= pd_day;
						wrk_q <= alu_diff;
					end else if (alu_ge) begin
						wrk_q  <= alu_diff;
						year_q <= ydec_year;
						m400_q <= ydec_m;
					end else begin
						state_q <= ST_MSUB;
					end
				end
				ST_MSUB: begin
					if (alu_ge) begin
						wrk_q <= alu_diff;
						mon_q <= pd_mon;
						day_q <= month_len(pd_mon, leap_cur);
						if (mon_q == MON_JAN) begin
							year_q <= ydec_year;
							m400_q <= ydec_m;
						end
					end else begin
						day_q   <= day_q - wrk_q[4:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready            = (state_q == ST_IDLE);
	assign stat.done           = (state_q == ST_DONE);
	assign stat.date.day_out   = day_q;
	assign stat.date.month_out = mon_q;
	assign stat.date.year_out  = 16'(year_q[LW-1:0]);

endmodule

// ===== rtl/calendar_date_add_subtract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date add/subtract
// Gregorian date register with load, next/previous day and day-count moves.
// ----------------------------------------------------------------------------
// Usage:
//   req : one transaction per request (load, next day, previous day, add or
//         subtract day_count days). ready is high only while the sequencer
//         is idle; it returns in the cycle the response turns valid.
//   rsp : one transaction per request with the date after it, held in an
//         output register. A new request may be accepted while a response
//         still waits there.
// Steps (a new request is taken once the last response is registered):
//   next/previous day or unused code: done directly from idle
//   load: eight-step modulo-400 reduction of the year, then clamping
//   add/subtract n: whole years, then whole months crossed (at most 12),
//     then the remaining days, plus leap-day steps; the loop runs through
//     the shared subtract/compare unit, one step per cycle.
// Reset: date becomes 1 January of year 1, no response pending.
// Stall: with the output register full and rsp.ready low, a finished request
//   waits in the sequencer and req.ready stays low.
// ----------------------------------------------------------------------------
module calendar_date_add_subtract import cda_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int YEAR_BITS  = YEAR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cda_req_if.sink   req,
	cda_rsp_if.source rsp
);

	seq_stat_t stat;
	logic      out_free;
	logic      rsp_valid_q;
	rsp_t      rsp_data_q;

	assign out_free = ~rsp_valid_q | rsp.ready;

	cda_seq #(
		.COUNT_BITS (COUNT_BITS),
		.YEAR_BITS  (YEAR_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_item  (req.payload),
		.out_free (out_free),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && out_free) begin
			rsp_data_q <= stat.date;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

endmodule
